FILE: sv/asid_pkg.sv
// Package for the Alpha subset instruction decoder.
// Holds opcode and operation codes, the page size and the decode result type.
// No dependencies.
package asid_pkg;

  // Page size in instructions
  localparam int unsigned PAGE_ENTRIES = 2048;
  // Address bits that lie inside one page (byte offset included)
  localparam logic [63:0] PAGE_MASK = ((64'(PAGE_ENTRIES) - 64'd1) << 2) | 64'd3;

  localparam logic [4:0] R31 = 5'd31;

  // Primary opcodes
  localparam logic [5:0] OPC_LDA   = 6'h08;
  localparam logic [5:0] OPC_LDAH  = 6'h09;
  localparam logic [5:0] OPC_LDBU  = 6'h0a;
  localparam logic [5:0] OPC_LDQ_U = 6'h0b;
  localparam logic [5:0] OPC_LDWU  = 6'h0c;
  localparam logic [5:0] OPC_STW   = 6'h0d;
  localparam logic [5:0] OPC_STB   = 6'h0e;
  localparam logic [5:0] OPC_INTA  = 6'h10;
  localparam logic [5:0] OPC_INTL  = 6'h11;
  localparam logic [5:0] OPC_INTS  = 6'h12;
  localparam logic [5:0] OPC_JMP   = 6'h1a;
  localparam logic [5:0] OPC_LDL   = 6'h28;
  localparam logic [5:0] OPC_LDQ   = 6'h29;
  localparam logic [5:0] OPC_STL   = 6'h2c;
  localparam logic [5:0] OPC_STQ   = 6'h2d;
  localparam logic [5:0] OPC_BR    = 6'h30;
  localparam logic [5:0] OPC_BEQ   = 6'h39;
  localparam logic [5:0] OPC_BLE   = 6'h3b;
  localparam logic [5:0] OPC_BNE   = 6'h3d;
  localparam logic [5:0] OPC_BGT   = 6'h3f;

  // Function codes (instruction bits 12:5, literal flag included)
  localparam logic [7:0] FN_CMPLE_LIT = 8'hed;
  localparam logic [7:0] FN_BIS       = 8'h20;
  localparam logic [7:0] FN_AND_LIT   = 8'h80;
  localparam logic [7:0] FN_SLL_LIT   = 8'hb9;

  // Jump hint that is not supported (coroutine)
  localparam logic [1:0] HINT_COROUTINE = 2'd3;

  // Dense operation codes
  localparam logic [5:0] OP_NOP        = 6'd0;
  localparam logic [5:0] OP_LDA        = 6'd1;
  localparam logic [5:0] OP_LDA_R31    = 6'd2;
  localparam logic [5:0] OP_LDBU       = 6'd3;
  localparam logic [5:0] OP_LDWU       = 6'd4;
  localparam logic [5:0] OP_STW        = 6'd5;
  localparam logic [5:0] OP_STB        = 6'd6;
  localparam logic [5:0] OP_LDL        = 6'd7;
  localparam logic [5:0] OP_LDQ        = 6'd8;
  localparam logic [5:0] OP_STL        = 6'd9;
  localparam logic [5:0] OP_STQ        = 6'd10;
  localparam logic [5:0] OP_ARITH_REG  = 6'd11;
  localparam logic [5:0] OP_ARITH_LIT  = 6'd23;
  localparam logic [5:0] OP_CMPLE_LIT  = 6'd35;
  localparam logic [5:0] OP_OR         = 6'd36;
  localparam logic [5:0] OP_CLEAR      = 6'd37;
  localparam logic [5:0] OP_AND_LIT    = 6'd38;
  localparam logic [5:0] OP_SLL_LIT    = 6'd39;
  localparam logic [5:0] OP_JSR        = 6'd40;
  localparam logic [5:0] OP_JSR_NOLINK = 6'd41;
  localparam logic [5:0] OP_BR         = 6'd42;
  localparam logic [5:0] OP_BR_LINK    = 6'd43;
  localparam logic [5:0] OP_BEQ        = 6'd44;
  localparam logic [5:0] OP_BLE        = 6'd45;
  localparam logic [5:0] OP_BNE        = 6'd46;
  localparam logic [5:0] OP_BGT        = 6'd47;
  localparam logic [5:0] OP_ILLEGAL    = 6'd48;

  localparam int unsigned ARITH_COUNT = 12;
  localparam logic [7:0] ARITH_CODES [ARITH_COUNT] = '{
    8'h00, 8'h02, 8'h09, 8'h0b, 8'h12, 8'h1b,
    8'h20, 8'h22, 8'h29, 8'h2b, 8'h32, 8'h3b
  };

  // Decoded fields of one instruction, branch target excluded
  typedef struct packed {
    logic [5:0]         op;
    logic [4:0]         dest_reg;
    logic [4:0]         src_a_reg;
    logic [4:0]         src_b_reg;
    logic               use_literal;
    logic [7:0]         literal;
    logic signed [31:0] displacement;
    logic               is_branch;
  } dec_t;

  // Dense op for an integer arithmetic function code, OP_ILLEGAL if none
  function automatic logic [5:0] arith_op(input logic [7:0] code);
    logic [5:0] res;
    res = OP_ILLEGAL;
    for (int i = 0; i < ARITH_COUNT; i++) begin
      if (code == ARITH_CODES[i]) begin
        res = OP_ARITH_REG + 6'(i);
      end else if (code == (ARITH_CODES[i] | 8'h80)) begin
        res = OP_ARITH_LIT + 6'(i);
      end
    end
    if (code == FN_CMPLE_LIT) begin
      res = OP_CMPLE_LIT;
    end
    return res;
  endfunction

endpackage

FILE: sv/asid_decode.sv
// Field decode of one instruction word into a dense op and operand fields.
// Depends on asid_pkg.
module asid_decode (
  input  logic [31:0]       instr_word,
  output asid_pkg::dec_t    dec
);
  import asid_pkg::*;

  logic [5:0]  opc;
  logic [4:0]  ra;
  logic [4:0]  rb;
  logic [4:0]  rc;
  logic [7:0]  code;
  logic [5:0]  oper_op;
  logic signed [31:0] disp16;

  assign opc    = instr_word[31:26];
  assign ra     = instr_word[25:21];
  assign rb     = instr_word[20:16];
  assign rc     = instr_word[4:0];
  assign code   = instr_word[12:5];
  assign disp16 = {{16{instr_word[15]}}, instr_word[15:0]};

  // Operate-format op selection
  always_comb begin
    oper_op = OP_ILLEGAL;
    case (opc)
      OPC_INTA: oper_op = arith_op(code);
      OPC_INTL: begin
        if (code == FN_BIS) begin
          oper_op = (ra == R31 && rb == R31) ? OP_CLEAR : OP_OR;
        end else if (code == FN_AND_LIT) begin
          oper_op = OP_AND_LIT;
        end
      end
      OPC_INTS: begin
        if (code == FN_SLL_LIT) begin
          oper_op = OP_SLL_LIT;
        end
      end
      default: oper_op = OP_ILLEGAL;
    endcase
  end

  // Main decode; fields unused by the op stay zero
  always_comb begin
    dec    = '0;
    dec.op = OP_ILLEGAL;
    case (opc)
      OPC_LDA, OPC_LDAH: begin
        if (ra == R31) begin
          dec.op = OP_NOP;
        end else begin
          dec.op           = (rb == R31) ? OP_LDA_R31 : OP_LDA;
          dec.dest_reg     = ra;
          dec.src_a_reg    = rb;
          dec.displacement = (opc == OPC_LDAH) ? {instr_word[15:0], 16'h0000} : disp16;
        end
      end
      OPC_LDQ_U: begin
        dec.op = (ra == R31) ? OP_NOP : OP_ILLEGAL;
      end
      OPC_LDBU, OPC_LDWU, OPC_LDL, OPC_LDQ: begin
        if (ra == R31) begin
          dec.op = OP_NOP;
        end else begin
          case (opc)
            OPC_LDBU: dec.op = OP_LDBU;
            OPC_LDWU: dec.op = OP_LDWU;
            OPC_LDL:  dec.op = OP_LDL;
            default:  dec.op = OP_LDQ;
          endcase
          dec.dest_reg     = ra;
          dec.src_a_reg    = rb;
          dec.displacement = disp16;
        end
      end
      OPC_STW, OPC_STB, OPC_STL, OPC_STQ: begin
        case (opc)
          OPC_STW: dec.op = OP_STW;
          OPC_STB: dec.op = OP_STB;
          OPC_STL: dec.op = OP_STL;
          default: dec.op = OP_STQ;
        endcase
        dec.dest_reg     = ra;
        dec.src_a_reg    = rb;
        dec.displacement = disp16;
      end
      OPC_INTA, OPC_INTL, OPC_INTS: begin
        if (rc == R31) begin
          dec.op = OP_NOP;
        end else if (oper_op != OP_ILLEGAL) begin
          dec.op        = oper_op;
          dec.dest_reg  = rc;
          dec.src_a_reg = ra;
          if (instr_word[12]) begin
            dec.use_literal = 1'b1;
            dec.literal     = instr_word[20:13];
          end else begin
            dec.src_b_reg = rb;
          end
        end
      end
      OPC_JMP: begin
        if (instr_word[15:14] != HINT_COROUTINE) begin
          dec.op        = (ra == R31) ? OP_JSR_NOLINK : OP_JSR;
          dec.dest_reg  = ra;
          dec.src_b_reg = rb;
        end
      end
      OPC_BR: begin
        dec.op        = (ra == R31) ? OP_BR : OP_BR_LINK;
        dec.dest_reg  = ra;
        dec.is_branch = 1'b1;
      end
      OPC_BEQ, OPC_BLE, OPC_BNE, OPC_BGT: begin
        case (opc)
          OPC_BEQ: dec.op = OP_BEQ;
          OPC_BLE: dec.op = OP_BLE;
          OPC_BNE: dec.op = OP_BNE;
          default: dec.op = OP_BGT;
        endcase
        dec.src_a_reg = ra;
        dec.is_branch = 1'b1;
      end
      default: dec.op = OP_ILLEGAL;
    endcase
  end

endmodule

FILE: sv/asid_target.sv
// Branch target adder and same-page compare.
// Depends on asid_pkg for the page mask.
module asid_target (
  input  logic [63:0] instr_addr,
  input  logic [31:0] instr_word,
  output logic [63:0] target,
  output logic        same_page
);
  import asid_pkg::*;

  logic [61:0] word_addr;
  logic [61:0] word_off;

  // Target in word units: (pc >> 2) + sext(disp21) + 1
  assign word_off  = {{41{instr_word[20]}}, instr_word[20:0]};
  assign word_addr = instr_addr[63:2] + word_off + 62'd1;
  assign target    = {word_addr, 2'b00};

  // Page match on the bits above the page offset
  assign same_page = (((instr_addr ^ target) & ~PAGE_MASK) == 64'd0);

endmodule

FILE: sv/alpha_subset_instruction_decoder.sv
// Alpha subset instruction decoder, top level.
// Input register, field decode and target logic, result register.
// Depends on asid_pkg, asid_decode and asid_target.
//
// Usage:
//   Input channel: in_valid / in_ready carry instr_addr and instr_word.
//   Output channel: out_valid / out_ready carry the decoded op, register
//   indices, literal, displacement, branch target and same_page flag.
//   Every accepted instruction gives exactly one result, in order.
//
//   An instruction transferred at a clock edge is captured in the input
//   register, decoded combinationally from it and captured in the result
//   register, which drives the outputs.
//   Throughput is one instruction per cycle while out_ready stays high; the
//   decode path between the two registers is the field decode plus one
//   62-bit target add.
//   When the receiver holds out_ready low the result register holds, the
//   input register takes one more instruction if it is empty, and then
//   in_ready drops until the result is transferred.
//   Reset (rst, synchronous) empties both registers; nothing else is kept.
module alpha_subset_instruction_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [63:0]        instr_addr,
  input  logic [31:0]        instr_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         op,
  output logic [4:0]         dest_reg,
  output logic [4:0]         src_a_reg,
  output logic [4:0]         src_b_reg,
  output logic               use_literal,
  output logic [7:0]         literal,
  output logic signed [31:0] displacement,
  output logic [63:0]        branch_target,
  output logic               same_page
);
  import asid_pkg::*;

  logic        s1_valid;
  logic [63:0] s1_addr;
  logic [31:0] s1_word;
  logic        s1_advance;
  dec_t        dec;
  logic [63:0] target;
  logic        target_same;

  // Stage 2 may load when empty or when its result is being transferred
  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_addr <= instr_addr;
      s1_word <= instr_word;
    end
  end

  asid_decode u_decode (
    .instr_word (s1_word),
    .dec        (dec)
  );

  asid_target u_target (
    .instr_addr (s1_addr),
    .instr_word (s1_word),
    .target     (target),
    .same_page  (target_same)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      op            <= dec.op;
      dest_reg      <= dec.dest_reg;
      src_a_reg     <= dec.src_a_reg;
      src_b_reg     <= dec.src_b_reg;
      use_literal   <= dec.use_literal;
      literal       <= dec.literal;
      displacement  <= dec.displacement;
      branch_target <= dec.is_branch ? target : 64'd0;
      same_page     <= dec.is_branch & target_same;
    end
  end

endmodule
